// File: rtl/core/laem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_pkg
// Load kinds, beat and result item types shared by the load align unit.
// ----------------------------------------------------------------------------
package laem_pkg;

    localparam logic [2:0] OP_LB   = 3'd0;
    localparam logic [2:0] OP_LBU  = 3'd1;
    localparam logic [2:0] OP_LH   = 3'd2;
    localparam logic [2:0] OP_LHU  = 3'd3;
    localparam logic [2:0] OP_LW   = 3'd4;
    localparam logic [2:0] OP_NONE = 3'd5;

    localparam logic [1:0] HELD_ONE   = 2'd1;
    localparam logic [1:0] HELD_TWO   = 2'd2;
    localparam logic [1:0] HELD_THREE = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] byte_address;
        logic [31:0] mem_word;
        logic        mem_enable;
    } beat_t;

    typedef struct packed {
        logic [31:0] load_data;
        logic        data_valid;
        logic        stall_res;
        logic [31:0] refetch_address;
    } result_t;

endpackage

// File: rtl/core/laem_beat_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_beat_if
// Load beat channel: valid/ready with op, address, memory word and enable.
// ----------------------------------------------------------------------------
interface laem_beat_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] byte_address;
    logic [31:0] mem_word;
    logic        mem_enable;

    modport source (output valid, output op, output byte_address, output mem_word,
                    output mem_enable, input ready);
    modport sink   (input valid, input op, input byte_address, input mem_word,
                    input mem_enable, output ready);
endinterface

// File: rtl/core/laem_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_result_if
// Load result channel: valid/ready with data, valid flag, stall and refetch.
// ----------------------------------------------------------------------------
interface laem_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] load_data;
    logic        data_valid;
    logic        stall_res;
    logic [31:0] refetch_address;

    modport source (output valid, output load_data, output data_valid,
                    output stall_res, output refetch_address, input ready);
    modport sink   (input valid, input load_data, input data_valid,
                    input stall_res, input refetch_address, output ready);
endinterface

// File: rtl/core/load_align_extend_misaligned_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_align_extend_misaligned_unit
// RV32 load data unit: selects and extends the loaded byte, halfword or word,
// and joins loads that cross a word boundary over two beats.
//
//   channel   role   handshake      payload
//   beat      sink   valid/ready    op, byte_address, mem_word, mem_enable
//   result    source valid/ready    load_data, data_valid, stall_res,
//                                   refetch_address
//
// One beat in, one result out; each beat passes the input register, then the result register.
// Sustained rate one beat per cycle while result is ready, set by both registers.
// A crossing load takes two beats; the first returns stall_res.
// Reset clears the split-pending flag and both stage valid flags.
// A stalled result sink holds both registers; beat.ready drops when full.
// ----------------------------------------------------------------------------
module load_align_extend_misaligned_unit (
    input  logic          clk,
    input  logic          rst_n,
    laem_beat_if.sink     beat,
    laem_result_if.source result
);

    logic              item_valid;
    laem_pkg::beat_t   item;
    laem_pkg::result_t aligned;
    logic              out_free;
    logic              take;

    assign take = item_valid && out_free;

    laem_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    laem_align u_align (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (take),
        .item    (item),
        .result  (aligned)
    );

    laem_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take),
        .item   (aligned),
        .free   (out_free),
        .result (result)
    );

endmodule

// File: rtl/core/laem_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_in_reg
// Input register: captures one load beat and holds it until taken.
// ----------------------------------------------------------------------------
module laem_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    laem_beat_if.sink       beat,
    input  logic            take,
    output logic            item_valid,
    output laem_pkg::beat_t item
);

    logic            valid_reg;
    logic            valid_next;
    laem_pkg::beat_t item_reg;

    assign beat.ready = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (beat.valid && beat.ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.valid && beat.ready)
        begin
            item_reg.op           <= beat.op;
            item_reg.byte_address <= beat.byte_address;
            item_reg.mem_word     <= beat.mem_word;
            item_reg.mem_enable   <= beat.mem_enable;
        end
    end

endmodule

// File: rtl/core/laem_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_align
// Byte/halfword/word select and extension, with split-load bookkeeping.
// ----------------------------------------------------------------------------
module laem_align (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  laem_pkg::beat_t   item,
    output laem_pkg::result_t result
);

    logic        split_pending_reg;
    logic        split_pending_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic [1:0]  held_reg;
    logic [1:0]  held_next;
    logic [2:0]  orig_op_reg;
    logic [2:0]  orig_op_next;

    logic [2:0]  op_c;
    logic [1:0]  off;
    logic [31:0] w;
    logic [7:0]  sel_byte;
    logic [15:0] sel_half;
    logic [15:0] join_half;
    logic [23:0] keep;
    logic        crossing;
    logic [31:0] data;
    logic        valid;

    assign off       = item.byte_address[1:0];
    assign w         = item.mem_word;
    assign op_c      = (item.op > laem_pkg::OP_NONE) ? laem_pkg::OP_NONE : item.op;
    assign join_half = {w[7:0], partial_reg[7:0]};
    assign crossing  = ((op_c == laem_pkg::OP_LH || op_c == laem_pkg::OP_LHU) && off == 2'd3)
                       || (op_c == laem_pkg::OP_LW && off != 2'd0);

    always_comb
    begin
        unique case (off)
            2'd0:    sel_byte = w[7:0];
            2'd1:    sel_byte = w[15:8];
            2'd2:    sel_byte = w[23:16];
            default: sel_byte = w[31:24];
        endcase
        unique case (off)
            2'd0:    sel_half = w[15:0];
            2'd1:    sel_half = w[23:8];
            default: sel_half = w[31:16];
        endcase
        unique case (off)
            2'd1:    keep = w[31:8];
            2'd2:    keep = {8'd0, w[31:16]};
            default: keep = {16'd0, w[31:24]};
        endcase
    end

    always_comb
    begin
        data               = 32'd0;
        valid              = 1'b0;
        split_pending_next = split_pending_reg;
        partial_next       = partial_reg;
        held_next          = held_reg;
        orig_op_next       = orig_op_reg;
        result.stall_res       = 1'b0;
        result.refetch_address = 32'd0;

        if (split_pending_reg)
        begin
            unique case (held_reg)
                laem_pkg::HELD_ONE:
                begin
                    if (orig_op_reg == laem_pkg::OP_LH)
                    begin
                        data = {{16{join_half[15]}}, join_half};
                    end
                    else if (orig_op_reg == laem_pkg::OP_LHU)
                    begin
                        data = {16'd0, join_half};
                    end
                    else
                    begin
                        data = {w[7:0], partial_reg};
                    end
                end
                laem_pkg::HELD_TWO:   data = {w[15:0], partial_reg[15:0]};
                laem_pkg::HELD_THREE: data = {w[23:0], partial_reg[7:0]};
                default:              data = 32'd0;
            endcase
            valid              = item.mem_enable;
            split_pending_next = 1'b0;
        end
        else if (crossing)
        begin
            result.stall_res       = 1'b1;
            result.refetch_address = {item.byte_address[31:2] + 30'd1, 2'b00};
            split_pending_next     = 1'b1;
            partial_next           = keep;
            held_next              = (op_c == laem_pkg::OP_LW) ? off : laem_pkg::HELD_ONE;
            orig_op_next           = op_c;
        end
        else
        begin
            unique case (op_c)
                laem_pkg::OP_LB:  data = {{24{sel_byte[7]}}, sel_byte};
                laem_pkg::OP_LBU: data = {24'd0, sel_byte};
                laem_pkg::OP_LH:  data = {{16{sel_half[15]}}, sel_half};
                laem_pkg::OP_LHU: data = {16'd0, sel_half};
                laem_pkg::OP_LW:  data = w;
                default:          data = 32'd0;
            endcase
            valid = item.mem_enable && (op_c != laem_pkg::OP_NONE);
        end

        result.load_data  = valid ? data : 32'd0;
        result.data_valid = valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            split_pending_reg <= split_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            partial_reg <= partial_next;
            held_reg    <= held_next;
            orig_op_reg <= orig_op_next;
        end
    end

    a_stall_arms_split: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.stall_res |=> split_pending_reg)
        else $error("split not armed after stall");

    a_second_beat_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && split_pending_reg |=> !split_pending_reg)
        else $error("split still pending after second beat");

    a_stall_excludes_data: assert property (@(posedge clk) disable iff (!rst_n)
        result.stall_res |-> !result.data_valid && result.load_data == 32'd0)
        else $error("data on a stalling beat");

    a_refetch_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        result.stall_res |-> result.refetch_address[1:0] == 2'b00)
        else $error("refetch address not word aligned");

endmodule

// File: rtl/core/laem_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laem_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module laem_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  laem_pkg::result_t item,
    output logic              free,
    laem_result_if.source     result
);

    logic              valid_reg;
    logic              valid_next;
    laem_pkg::result_t item_reg;

    assign free                   = !valid_reg || result.ready;
    assign result.valid           = valid_reg;
    assign result.load_data       = item_reg.load_data;
    assign result.data_valid      = item_reg.data_valid;
    assign result.stall_res       = item_reg.stall_res;
    assign result.refetch_address = item_reg.refetch_address;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

endmodule
